FILE: hw/rtl/rpbd_pkg.sv
// Shared types and codes for the rotated packed bitmap drawer.
package rpbd_pkg;

    localparam int CoordWidth = 11;

    typedef enum logic [2:0] {
        MODE_WRITE_PIXEL = 3'd0,
        MODE_READ_ROT    = 3'd1,
        MODE_READ_RAW    = 3'd2,
        MODE_HLINE       = 3'd3,
        MODE_VLINE       = 3'd4,
        MODE_FILL        = 3'd5
    } mode_t;

    typedef enum logic [1:0] {
        OP_NONE  = 2'd0,
        OP_WRITE = 2'd1,
        OP_READ  = 2'd2,
        OP_FILL  = 2'd3
    } op_t;

    typedef struct packed {
        op_t                   op;
        logic [CoordWidth-1:0] cx;
        logic [CoordWidth-1:0] cy;
        logic [CoordWidth-1:0] count;
        logic                  step_y;
        logic                  raw;
        logic                  on;
        logic                  off;
    } cmd_t;

endpackage

FILE: hw/rtl/rpbd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rpbd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 80
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

FILE: hw/rtl/rpbd_front.sv
// Front end: classifies and clips one command into a back-end command.
module rpbd_front #(
    parameter int PANEL_WIDTH  = 32,
    parameter int PANEL_HEIGHT = 16
) (
    input  logic [2:0]          mode,
    input  logic signed [10:0]  x_coord,
    input  logic signed [10:0]  y_coord,
    input  logic signed [10:0]  line_length,
    input  logic                pixel_on,
    input  logic [1:0]          rotation,
    output rpbd_pkg::cmd_t      cmd
);
    import rpbd_pkg::*;

    localparam logic signed [12:0] PW = 13'(PANEL_WIDTH);
    localparam logic signed [12:0] PH = 13'(PANEL_HEIGHT);

    logic signed [12:0] x, y, ln, rw, rh, alim, flim, fix, st0, n, st1, len1, st2, len2;
    logic               horiz, reject, in_rot, in_raw;

    always_comb
    begin
        x  = 13'(x_coord);
        y  = 13'(y_coord);
        ln = 13'(line_length);
        rw = rotation[0] ? PH : PW;
        rh = rotation[0] ? PW : PH;
        horiz = (mode == MODE_HLINE);
        st0  = horiz ? x : y;
        fix  = horiz ? y : x;
        alim = horiz ? rw : rh;
        flim = horiz ? rh : rw;

        // fold a backwards line onto its low end
        n    = -ln;
        st1  = st0;
        len1 = ln;
        if (ln < 0)
        begin
            st1  = st0 - n + 13'sd1;
            len1 = n;
            if (st1 < 0)
            begin
                len1 = n + st1;
                st1  = '0;
            end
        end
        reject = (fix < 0) || (fix >= flim) || (st1 >= alim) || (st1 + len1 - 13'sd1 < 0);

        st2  = st1;
        len2 = len1;
        if (st2 < 0)
        begin
            len2 = len1 + st2;
            st2  = '0;
        end
        if (st2 + len2 > alim)
        begin
            len2 = alim - st2;
        end

        in_rot = (x >= 0) && (y >= 0) && (x < rw) && (y < rh);
        in_raw = (x >= 0) && (y >= 0) && (x < PW) && (y < PH);

        cmd        = '0;
        cmd.on     = pixel_on;
        cmd.cx     = x[10:0];
        cmd.cy     = y[10:0];
        cmd.count  = 11'd1;
        unique case (mode)
            MODE_WRITE_PIXEL:
            begin
                cmd.op  = in_rot ? OP_WRITE : OP_NONE;
                cmd.off = !in_rot;
            end
            MODE_READ_ROT:
            begin
                cmd.op  = in_rot ? OP_READ : OP_NONE;
                cmd.off = !in_rot;
            end
            MODE_READ_RAW:
            begin
                cmd.op  = in_raw ? OP_READ : OP_NONE;
                cmd.off = !in_raw;
                cmd.raw = 1'b1;
            end
            MODE_HLINE, MODE_VLINE:
            begin
                cmd.op     = (reject || len2 == 0) ? OP_NONE : OP_WRITE;
                cmd.off    = reject;
                cmd.cx     = horiz ? st2[10:0] : fix[10:0];
                cmd.cy     = horiz ? fix[10:0] : st2[10:0];
                cmd.step_y = !horiz;
                cmd.count  = len2[10:0];
            end
            MODE_FILL:
            begin
                cmd.op = OP_FILL;
            end
            default:
            begin
                cmd.op = OP_NONE;
            end
        endcase
    end
endmodule

FILE: hw/rtl/rpbd_queue.sv
// Two-entry command queue between front and back end.
module rpbd_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  rpbd_pkg::cmd_t push_data,
    input  logic           pop,
    output rpbd_pkg::cmd_t pop_data,
    output logic           full,
    output logic           empty
);
    import rpbd_pkg::*;

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [1:0] fill_reg, fill_next;

    assign full     = (fill_reg == 2'd2);
    assign empty    = (fill_reg == 2'd0);
    assign pop_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        fill_next   = fill_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end
endmodule

FILE: hw/rtl/rpbd_back.sv
// Back end: maps, addresses, reads, read-modify-writes, clears and fills the frame store.
module rpbd_back #(
    parameter int PANEL_WIDTH   = 32,
    parameter int PANEL_HEIGHT  = 16,
    parameter int BITS_PER_WORD = 7
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic [1:0]     rotation,
    input  logic           q_empty,
    input  rpbd_pkg::cmd_t q_data,
    output logic           q_pop,
    output logic           clearing,
    output logic           pixel_value,
    output logic           off_canvas,
    output logic           out_valid,
    input  logic           out_stall
);
    import rpbd_pkg::*;

    localparam int RowBytes = (PANEL_WIDTH + BITS_PER_WORD - 1) / BITS_PER_WORD;
    localparam int Depth    = RowBytes * PANEL_HEIGHT;
    localparam int Aw       = Depth > 1 ? $clog2(Depth) : 1;
    localparam int Recip    = (65536 + BITS_PER_WORD - 1) / BITS_PER_WORD;
    localparam logic [10:0] PwM1 = 11'(PANEL_WIDTH - 1);
    localparam logic [10:0] PhM1 = 11'(PANEL_HEIGHT - 1);
    localparam logic [Aw-1:0] LastAddr = Aw'(Depth - 1);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_CLEAR = 8'b0000_0010,
        S_MAP   = 8'b0000_0100,
        S_DIV   = 8'b0000_1000,
        S_ADDR  = 8'b0001_0000,
        S_RD    = 8'b0010_0000,
        S_MOD   = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } state_t;

    state_t         state_reg, state_next;
    cmd_t           cmd_reg, cmd_next;
    logic           init_reg, init_next;
    logic           val_reg, val_next;
    logic [10:0]    rx_reg, rx_next, ry_reg, ry_next, q_reg, q_next;
    logic [Aw-1:0]  row_reg, row_next, addr_reg, addr_next, clr_reg, clr_next;
    logic [2:0]     bit_reg, bit_next;
    logic           ov_reg, ov_next, pv_reg, pv_next, oc_reg, oc_next;
    logic           ram_we;
    logic [Aw-1:0]  ram_waddr;
    logic [7:0]     ram_wdata, ram_rdata, mask;
    logic [27:0]    prod;
    logic [21:0]    row_prod;

    rpbd_ram #(.WIDTH(8), .DEPTH(Depth)) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (addr_reg),
        .rdata (ram_rdata)
    );

    assign clearing    = init_reg;
    assign out_valid   = ov_reg;
    assign pixel_value = pv_reg;
    assign off_canvas  = oc_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        init_next  = init_reg;
        val_next   = val_reg;
        rx_next    = rx_reg;
        ry_next    = ry_reg;
        q_next     = q_reg;
        row_next   = row_reg;
        addr_next  = addr_reg;
        bit_next   = bit_reg;
        clr_next   = clr_reg;
        ov_next    = ov_reg && out_stall;
        pv_next    = pv_reg;
        oc_next    = oc_reg;
        q_pop      = 1'b0;
        ram_we     = 1'b0;
        ram_waddr  = addr_reg;
        mask       = 8'(1) << bit_reg;
        ram_wdata  = cmd_reg.on ? (ram_rdata | mask) : (ram_rdata & ~mask);
        prod       = 28'(rx_reg) * 28'(Recip);
        row_prod   = 22'(ry_reg) * 22'(RowBytes);

        unique case (state_reg)
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop    = 1'b1;
                    cmd_next = q_data;
                    val_next = 1'b0;
                    clr_next = '0;
                    unique case (q_data.op)
                        OP_WRITE, OP_READ: state_next = S_MAP;
                        OP_FILL:           state_next = S_CLEAR;
                        default:           state_next = S_DONE;
                    endcase
                end
            end
            S_CLEAR:
            begin
                // sweep the store: zero after reset, or the fill colour
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = (!init_reg && cmd_reg.on) ? 8'hFF : 8'h00;
                clr_next  = clr_reg + Aw'(1);
                if (clr_reg == LastAddr)
                begin
                    init_next  = 1'b0;
                    state_next = init_reg ? S_IDLE : S_DONE;
                end
            end
            S_MAP:
            begin
                rx_next = cmd_reg.cx;
                ry_next = cmd_reg.cy;
                if (!cmd_reg.raw)
                begin
                    unique case (rotation)
                        2'd1:
                        begin
                            rx_next = PwM1 - cmd_reg.cy;
                            ry_next = cmd_reg.cx;
                        end
                        2'd2:
                        begin
                            rx_next = PwM1 - cmd_reg.cx;
                            ry_next = PhM1 - cmd_reg.cy;
                        end
                        2'd3:
                        begin
                            rx_next = cmd_reg.cy;
                            ry_next = PhM1 - cmd_reg.cx;
                        end
                        default:
                        begin
                            rx_next = cmd_reg.cx;
                            ry_next = cmd_reg.cy;
                        end
                    endcase
                end
                state_next = S_DIV;
            end
            S_DIV:
            begin
                // byte column by reciprocal multiply, exact for 10-bit columns
                q_next     = prod[26:16];
                row_next   = Aw'(row_prod);
                state_next = S_ADDR;
            end
            S_ADDR:
            begin
                addr_next  = Aw'(q_reg) + row_reg;
                bit_next   = 3'(rx_reg - 11'(q_reg * 11'(BITS_PER_WORD)));
                state_next = S_RD;
            end
            S_RD:
            begin
                state_next = S_MOD;
            end
            S_MOD:
            begin
                if (cmd_reg.op == OP_READ)
                begin
                    val_next   = ram_rdata[bit_reg];
                    state_next = S_DONE;
                end
                else
                begin
                    ram_we         = 1'b1;
                    cmd_next.count = cmd_reg.count - 11'd1;
                    if (cmd_reg.step_y)
                    begin
                        cmd_next.cy = cmd_reg.cy + 11'd1;
                    end
                    else
                    begin
                        cmd_next.cx = cmd_reg.cx + 11'd1;
                    end
                    state_next = (cmd_reg.count == 11'd1) ? S_DONE : S_MAP;
                end
            end
            S_DONE:
            begin
                if (!ov_next)
                begin
                    ov_next    = 1'b1;
                    pv_next    = val_reg;
                    oc_next    = cmd_reg.off;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        val_reg  <= val_next;
        rx_reg   <= rx_next;
        ry_reg   <= ry_next;
        q_reg    <= q_next;
        row_reg  <= row_next;
        addr_reg <= addr_next;
        bit_reg  <= bit_next;
        pv_reg   <= pv_next;
        oc_reg   <= oc_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            init_reg  <= 1'b1;
            clr_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            init_reg  <= init_next;
            clr_reg   <= clr_next;
            ov_reg    <= ov_next;
        end
    end
endmodule

FILE: hw/rtl/rotated_packed_bitmap_drawer.sv
// Top level of the rotated packed bitmap drawer.
//
// A one-bit-per-pixel frame store, BITS_PER_WORD pixels to a byte and
// ceil(PANEL_WIDTH / BITS_PER_WORD) bytes to a row, drawn in rotated
// coordinates. Each accepted item returns exactly one result item. The
// front end clips and classifies an item and drops it into a two-entry
// queue; the back end walks it pixel by pixel through the store, a
// single-port-write RAM with registered read. Each pixel of a line is
// one read-modify-write of its byte; a fill sweeps the store at one
// byte a cycle. After reset the same sweep clears the store, and no
// item is accepted until it ends. Write the rotation register only
// while the block is idle.
module rotated_packed_bitmap_drawer #(
    parameter int PANEL_WIDTH   = 32,
    parameter int PANEL_HEIGHT  = 16,
    parameter int BITS_PER_WORD = 7
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [2:0]         mode,
    input  logic signed [10:0] x_coord,
    input  logic signed [10:0] y_coord,
    input  logic signed [10:0] line_length,
    input  logic               pixel_on,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               pixel_value,
    output logic               off_canvas,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_data
);
    import rpbd_pkg::*;

    logic [1:0] rotation_reg, rotation_next;
    cmd_t       front_cmd, q_data;
    logic       q_full, q_empty, q_pop, push, clearing;

    // always ready: the user writes only while idle, the block does not enforce it
    assign cfg_ready = 1'b1;
    assign rotation_next = (cfg_valid && cfg_ready) ? cfg_data : rotation_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rotation_reg <= 2'd0;
        end
        else
        begin
            rotation_reg <= rotation_next;
        end
    end

    // hold items off while the queue is full or the store is being cleared after reset
    assign in_stall = q_full || clearing;
    assign push     = in_valid && !in_stall;

    rpbd_front #(
        .PANEL_WIDTH  (PANEL_WIDTH),
        .PANEL_HEIGHT (PANEL_HEIGHT)
    ) u_front (
        .mode        (mode),
        .x_coord     (x_coord),
        .y_coord     (y_coord),
        .line_length (line_length),
        .pixel_on    (pixel_on),
        .rotation    (rotation_reg),
        .cmd         (front_cmd)
    );

    rpbd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (front_cmd),
        .pop       (q_pop),
        .pop_data  (q_data),
        .full      (q_full),
        .empty     (q_empty)
    );

    rpbd_back #(
        .PANEL_WIDTH   (PANEL_WIDTH),
        .PANEL_HEIGHT  (PANEL_HEIGHT),
        .BITS_PER_WORD (BITS_PER_WORD)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .rotation    (rotation_reg),
        .q_empty     (q_empty),
        .q_data      (q_data),
        .q_pop       (q_pop),
        .clearing    (clearing),
        .pixel_value (pixel_value),
        .off_canvas  (off_canvas),
        .out_valid   (out_valid),
        .out_stall   (out_stall)
    );
endmodule

FILE: dv/rotated_packed_bitmap_drawer_tb.sv
// Self-checking testbench for the rotated packed bitmap drawer.
module rotated_packed_bitmap_drawer_tb;
    import rpbd_pkg::*;

    localparam int PanelW   = 32;
    localparam int PanelH   = 16;
    localparam int PackBits = 7;
    localparam int RowBytes = (PanelW + PackBits - 1) / PackBits;
    localparam int Depth    = RowBytes * PanelH;
    localparam int CycleLimit = 2000000;

    typedef struct packed {
        logic [2:0]         mode;
        logic signed [10:0] xc;
        logic signed [10:0] yc;
        logic signed [10:0] len;
        logic               on;
    } cmd_item_t;

    typedef struct packed {
        logic value;
        logic off;
    } pix_result_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic [2:0] mode;
    logic signed [10:0] x_coord, y_coord, line_length;
    logic pixel_on;
    logic out_valid;
    logic out_stall;
    logic pixel_value, off_canvas;
    logic cfg_valid, cfg_ready;
    logic [1:0] cfg_data;

    rotated_packed_bitmap_drawer #(
        .PANEL_WIDTH(PanelW), .PANEL_HEIGHT(PanelH), .BITS_PER_WORD(PackBits)
    ) u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .mode(mode), .x_coord(x_coord), .y_coord(y_coord),
        .line_length(line_length), .pixel_on(pixel_on),
        .out_valid(out_valid), .out_stall(out_stall),
        .pixel_value(pixel_value), .off_canvas(off_canvas),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    // Predictor state: a private copy of the frame store and the rotation.
    logic [7:0] shadow_store [Depth];
    logic [1:0] shadow_rot;

    cmd_item_t   pending_cmds[$];
    pix_result_t awaited_results[$];
    int  mismatches;
    int  cycles;
    bit  calm_phase;      // no idling in the last part of the run
    bit  long_hold_req;   // ask the receiver for a long hold-off

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int rot_w();
        return shadow_rot[0] ? PanelH : PanelW;
    endfunction

    function automatic int rot_h();
        return shadow_rot[0] ? PanelW : PanelH;
    endfunction

    function automatic void map_to_raw(input int x, input int y, output int rx, output int ry);
        case (shadow_rot)
            2'd1: begin rx = PanelW - 1 - y; ry = x; end
            2'd2: begin rx = PanelW - 1 - x; ry = PanelH - 1 - y; end
            2'd3: begin rx = y; ry = PanelH - 1 - x; end
            default: begin rx = x; ry = y; end
        endcase
    endfunction

    function automatic bit raw_ok(int rx, int ry);
        return rx >= 0 && ry >= 0 && rx < PanelW && ry < PanelH;
    endfunction

    function automatic logic peek_pixel(int rx, int ry);
        return shadow_store[rx / PackBits + ry * RowBytes][rx % PackBits];
    endfunction

    function automatic void poke_pixel(input int rx, input int ry, input logic on);
        if (raw_ok(rx, ry))
            shadow_store[rx / PackBits + ry * RowBytes][rx % PackBits] = on;
    endfunction

    // Draw along one rotated axis; returns 1 when the whole line is rejected.
    function automatic bit trace_line(int fixed, int start, int len, bit horiz, logic on);
        int along, across, rx, ry;
        along  = horiz ? rot_w() : rot_h();
        across = horiz ? rot_h() : rot_w();
        if (len < 0) begin
            len = -len;
            start -= len - 1;
            if (start < 0) begin
                len += start;
                start = 0;
            end
        end
        if (fixed < 0 || fixed >= across || start >= along || start + len - 1 < 0)
            return 1'b1;
        if (start < 0) begin
            len += start;
            start = 0;
        end
        if (start + len > along)
            len = along - start;
        for (int i = 0; i < len; i++) begin
            if (horiz) map_to_raw(start + i, fixed, rx, ry);
            else       map_to_raw(fixed, start + i, rx, ry);
            poke_pixel(rx, ry, on);
        end
        return 1'b0;
    endfunction

    function automatic pix_result_t render_cmd(cmd_item_t c);
        pix_result_t r;
        int x, y, rx, ry;
        r = '0;
        x = c.xc;
        y = c.yc;
        case (c.mode)
            MODE_WRITE_PIXEL: begin
                if (x < 0 || y < 0 || x >= rot_w() || y >= rot_h()) r.off = 1'b1;
                else begin
                    map_to_raw(x, y, rx, ry);
                    poke_pixel(rx, ry, c.on);
                end
            end
            MODE_READ_ROT: begin
                map_to_raw(x, y, rx, ry);
                if (raw_ok(rx, ry)) r.value = peek_pixel(rx, ry);
                else r.off = 1'b1;
            end
            MODE_READ_RAW: begin
                if (raw_ok(x, y)) r.value = peek_pixel(x, y);
                else r.off = 1'b1;
            end
            MODE_HLINE: r.off = trace_line(y, x, c.len, 1'b1, c.on);
            MODE_VLINE: r.off = trace_line(x, y, c.len, 1'b0, c.on);
            MODE_FILL: begin
                for (int i = 0; i < Depth; i++) shadow_store[i] = c.on ? 8'hFF : 8'h00;
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        $display("MISMATCH at cycle %0d: %s", cycles, what);
        mismatches++;
    endtask

    // Driver: offer the head of the pending queue, idling in random bursts.
    int drv_gap;
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_valid    <= 1'b0;
            mode        <= '0;
            x_coord     <= '0;
            y_coord     <= '0;
            line_length <= '0;
            pixel_on    <= 1'b0;
            drv_gap     <= 0;
        end else begin
            automatic bit taken = in_valid && !in_stall;
            if (taken) begin
                // Predict at acceptance so the shadow store follows block order.
                awaited_results.push_back(render_cmd(pending_cmds.pop_front()));
            end
            if (in_valid && !taken) begin
                // hold the stalled item
            end else if (drv_gap > 0) begin
                drv_gap  <= drv_gap - 1;
                in_valid <= 1'b0;
            end else if (pending_cmds.size() > 0 && !calm_phase && $urandom_range(0, 9) == 0
                         && !taken) begin
                drv_gap  <= $urandom_range(1, 12) - 1;
                in_valid <= 1'b0;
            end else if (pending_cmds.size() > 0) begin
                in_valid    <= 1'b1;
                mode        <= pending_cmds[0].mode;
                x_coord     <= pending_cmds[0].xc;
                y_coord     <= pending_cmds[0].yc;
                line_length <= pending_cmds[0].len;
                pixel_on    <= pending_cmds[0].on;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver stall: random bursts, plus a long hold-off on request.
    int stall_left;
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end else if (long_hold_req && stall_left == 0 && !out_stall) begin
            out_stall  <= 1'b1;
            stall_left <= 400;
        end else if (stall_left > 1) begin
            stall_left <= stall_left - 1;
        end else if (stall_left == 1) begin
            stall_left <= 0;
            out_stall  <= 1'b0;
        end else if (!calm_phase && $urandom_range(0, 11) == 0) begin
            out_stall  <= 1'b1;
            stall_left <= $urandom_range(1, 12);
        end else begin
            out_stall <= 1'b0;
        end
    end

    // Monitor: compare each accepted result with the oldest expectation.
    always @(posedge clk) begin
        if (rst_n) begin
            cycles <= cycles + 1;
            if (out_valid && !out_stall) begin
                if (awaited_results.size() == 0)
                    report_mismatch("result with nothing expected");
                else begin
                    automatic pix_result_t e = awaited_results.pop_front();
                    if (pixel_value !== e.value)
                        report_mismatch($sformatf("pixel_value %b, expected %b",
                                                  pixel_value, e.value));
                    if (off_canvas !== e.off)
                        report_mismatch($sformatf("off_canvas %b, expected %b",
                                                  off_canvas, e.off));
                end
            end
            if (cycles > CycleLimit) begin
                $display("rotated_packed_bitmap_drawer_tb failed");
                $finish;
            end
        end
    end

    function automatic logic signed [10:0] pick_coord(int span);
        case ($urandom_range(0, 9))
            0:       return 11'($urandom);                 // full range noise
            1:       return 11'($urandom_range(0, 7) - 4); // around zero
            2:       return 11'(span + $urandom_range(0, 3) - 2);
            default: return 11'($urandom_range(0, span - 1));
        endcase
    endfunction

    function automatic cmd_item_t random_cmd();
        cmd_item_t c;
        c.mode = $urandom_range(0, 19) == 0 ? 3'($urandom_range(6, 7))
                                            : 3'($urandom_range(0, 5));
        if (c.mode == MODE_FILL && $urandom_range(0, 3) != 0) c.mode = MODE_READ_ROT;
        c.xc  = pick_coord(PanelW);
        c.yc  = pick_coord(PanelW);
        c.len = $urandom_range(0, 5) == 0 ? 11'($urandom)
                                          : 11'($urandom_range(0, 80) - 40);
        c.on  = 1'($urandom);
        return c;
    endfunction

    task automatic queue_cmd(input logic [2:0] m, input int x, input int y,
                             input int l, input logic on);
        cmd_item_t c;
        c.mode = m; c.xc = 11'(x); c.yc = 11'(y); c.len = 11'(l); c.on = on;
        pending_cmds.push_back(c);
    endtask

    // Wait until every queued item has been taken and answered, then let
    // the block settle before touching the rotation register.
    task automatic drain();
        while (pending_cmds.size() > 0 || in_valid || awaited_results.size() > 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic set_rotation(input logic [1:0] r);
        cfg_valid <= 1'b1;
        cfg_data  <= r;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        shadow_rot = r;
    endtask

    initial begin
        rst_n         = 1'b0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        calm_phase    = 1'b0;
        long_hold_req = 1'b0;
        mismatches    = 0;
        cycles        = 0;
        shadow_rot    = '0;
        for (int i = 0; i < Depth; i++) shadow_store[i] = 8'h00;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extremes, every mode, clipping and rejection cases.
        set_rotation(2'd0);
        queue_cmd(MODE_WRITE_PIXEL, 0, 0, 0, 1'b1);
        queue_cmd(MODE_WRITE_PIXEL, PanelW - 1, PanelH - 1, 0, 1'b1);
        queue_cmd(MODE_WRITE_PIXEL, -1, 0, 0, 1'b1);
        queue_cmd(MODE_WRITE_PIXEL, 1023, -1024, 0, 1'b1);
        queue_cmd(MODE_READ_ROT, 0, 0, 0, 1'b0);
        queue_cmd(MODE_READ_ROT, PanelW, 0, 0, 1'b0);
        queue_cmd(MODE_READ_RAW, PanelW - 1, PanelH - 1, 0, 1'b0);
        queue_cmd(MODE_READ_RAW, -1024, 1023, 0, 1'b0);
        queue_cmd(MODE_HLINE, 3, 2, 20, 1'b1);
        queue_cmd(MODE_HLINE, 10, 4, -30, 1'b1);
        queue_cmd(MODE_HLINE, -5, 5, 1023, 1'b1);
        queue_cmd(MODE_HLINE, 0, 6, 0, 1'b1);
        queue_cmd(MODE_HLINE, 4, 6, 0, 1'b1);
        queue_cmd(MODE_HLINE, PanelW, 1, 5, 1'b1);
        queue_cmd(MODE_HLINE, -10, 1, 5, 1'b1);
        queue_cmd(MODE_VLINE, 7, 0, -1024, 1'b1);
        queue_cmd(MODE_VLINE, 8, 3, 9, 1'b1);
        queue_cmd(MODE_VLINE, -1, 3, 9, 1'b1);
        queue_cmd(MODE_READ_RAW, 8, 5, 0, 1'b0);
        queue_cmd(3'd6, 1, 1, 1, 1'b1);
        queue_cmd(3'd7, 1, 1, 1, 1'b1);
        queue_cmd(MODE_FILL, 0, 0, 0, 1'b1);
        queue_cmd(MODE_READ_ROT, 5, 5, 0, 1'b0);
        queue_cmd(MODE_FILL, 0, 0, 0, 1'b0);
        drain();

        // Random phases across every rotation; the sender pauses at each drain.
        for (int ph = 0; ph < 8; ph++) begin
            set_rotation(2'(ph % 4));
            if (ph == 2) long_hold_req = 1'b1;
            if (ph == 6) calm_phase = 1'b1;
            for (int n = 0; n < 150; n++) pending_cmds.push_back(random_cmd());
            if (ph == 2) begin
                repeat (20) @(posedge clk);
                long_hold_req = 1'b0;
            end
            drain();
        end
        drain();

        if (mismatches == 0 && awaited_results.size() == 0)
            $display("rotated_packed_bitmap_drawer_tb passed");
        else
            $display("rotated_packed_bitmap_drawer_tb failed");
        $finish;
    end

endmodule

FILE: filelist.f
hw/rtl/rpbd_pkg.sv
hw/rtl/rpbd_ram.sv
hw/rtl/rpbd_front.sv
hw/rtl/rpbd_queue.sv
hw/rtl/rpbd_back.sv
hw/rtl/rotated_packed_bitmap_drawer.sv
dv/rotated_packed_bitmap_drawer_tb.sv
